[design/pwsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsc_pkg - shared definitions for the pulse wave sound channel
// Command codes, register numbers, bit positions and the fixed length and
// duty tables of the channel.
// ----------------------------------------------------------------------------
package pwsc_pkg;

	typedef enum logic [2:0] {
		CMD_WRITE   = 3'd0,
		CMD_TICK    = 3'd1,
		CMD_QUARTER = 3'd2,
		CMD_HALF    = 3'd3,
		CMD_ENABLE  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CTRL   = 2'd0,
		REG_SWEEP  = 2'd1,
		REG_PER_LO = 2'd2,
		REG_PER_HI = 2'd3
	} reg_t;

	localparam int unsigned PERIOD_W = 11;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'd8;
	localparam logic [3:0] DECAY_MAX = 4'd15;

	// sweep register bit positions
	localparam int unsigned SWP_ENABLE_BIT = 7;
	localparam int unsigned SWP_NEGATE_BIT = 3;

	typedef struct packed {
		logic [PERIOD_W-1:0] target;
		logic                muted;
	} sweep_t;

	function automatic logic [7:0] length_load(input logic [4:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0:  v = 8'd10;
			5'd1:  v = 8'd254;
			5'd2:  v = 8'd20;
			5'd3:  v = 8'd2;
			5'd4:  v = 8'd40;
			5'd5:  v = 8'd4;
			5'd6:  v = 8'd80;
			5'd7:  v = 8'd6;
			5'd8:  v = 8'd160;
			5'd9:  v = 8'd8;
			5'd10: v = 8'd60;
			5'd11: v = 8'd10;
			5'd12: v = 8'd14;
			5'd13: v = 8'd12;
			5'd14: v = 8'd26;
			5'd15: v = 8'd14;
			5'd16: v = 8'd12;
			5'd17: v = 8'd16;
			5'd18: v = 8'd24;
			5'd19: v = 8'd18;
			5'd20: v = 8'd48;
			5'd21: v = 8'd20;
			5'd22: v = 8'd96;
			5'd23: v = 8'd22;
			5'd24: v = 8'd192;
			5'd25: v = 8'd24;
			5'd26: v = 8'd72;
			5'd27: v = 8'd26;
			5'd28: v = 8'd16;
			5'd29: v = 8'd28;
			5'd30: v = 8'd32;
			default: v = 8'd30;
		endcase
		return v;
	endfunction

	// bit k of the pattern is the output at sequencer step k
	function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
		logic [7:0] v;
		case (sel)
			2'd0: v = 8'h02;
			2'd1: v = 8'h06;
			2'd2: v = 8'h1E;
			default: v = 8'hF9;
		endcase
		return v;
	endfunction

endpackage

[design/pwsc_sweep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsc_sweep - sweep target and period mute
// Shifts the period, adds or subtracts it, and flags a mute when the period
// is too small or the target overflows 11 bits.
// ----------------------------------------------------------------------------
module pwsc_sweep (
	input  logic [pwsc_pkg::PERIOD_W-1:0] period,
	input  logic [7:0]                    settings,
	input  logic                          second_channel,
	output pwsc_pkg::sweep_t              sweep
);

	logic [pwsc_pkg::PERIOD_W-1:0] change;
	logic [pwsc_pkg::PERIOD_W:0]   sum;
	logic                          negate;

	always_comb begin
		change = period >> settings[2:0];
		negate = settings[pwsc_pkg::SWP_NEGATE_BIT];
		if (negate) begin
			// first channel subtracts one more (ones' complement)
			sum = {1'b0, period} - {1'b0, change} - {{pwsc_pkg::PERIOD_W{1'b0}}, ~second_channel};
		end else begin
			sum = {1'b0, period} + {1'b0, change};
		end
		sweep.target = sum[pwsc_pkg::PERIOD_W-1:0];
		// a negative target never mutes
		sweep.muted = (period < pwsc_pkg::PERIOD_MIN) || (!negate && sum[pwsc_pkg::PERIOD_W]);
	end

endmodule

[design/pulse_wave_sound_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_wave_sound_channel - square-wave sound channel
// Channel registers, period timer, duty sequencer, length counter, sweep and
// decay envelope, with one sample result per request.
// ----------------------------------------------------------------------------
// One request is taken every clock while in_stall is low. A request is
// captured in an input register, applied to the channel state by one pass
// of short logic once the output can take it, and its result lands in
// the output register with out_valid set. A stalled result blocks new requests
// only once the input register is also full. Writes to second_channel are
// taken at any time (cfg_ready is always high) and belong between requests.
module pulse_wave_sound_channel (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,

	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [1:0] reg_index,
	input  logic [7:0] reg_value,
	input  logic       enable_value,

	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] sample,
	output logic       length_active
);

	localparam int unsigned PW = pwsc_pkg::PERIOD_W;

	logic second_channel_q;

	// input stage
	logic       valid_s1;
	logic [2:0] command_s1;
	logic [1:0] reg_index_s1;
	logic [7:0] reg_value_s1;
	logic       enable_value_s1;

	// channel state
	logic [1:0]    duty_select_q, duty_select_d;
	logic          loop_halt_q, loop_halt_d;
	logic          const_vol_q, const_vol_d;
	logic [3:0]    volume_q, volume_d;
	logic [7:0]    sweep_set_q, sweep_set_d;
	logic          sweep_reload_q, sweep_reload_d;
	logic [2:0]    sweep_div_q, sweep_div_d;
	logic [PW-1:0] period_q, period_d;
	logic [PW-1:0] timer_q, timer_d;
	logic [2:0]    step_q, step_d;
	logic          phase_q, phase_d;
	logic [7:0]    length_q, length_d;
	logic          enabled_q, enabled_d;
	logic          env_start_q, env_start_d;
	logic [3:0]    env_div_q, env_div_d;
	logic [3:0]    decay_q, decay_d;

	// output stage
	logic       out_valid_q;
	logic [3:0] sample_q;
	logic       length_active_q;

	logic             move;
	pwsc_pkg::sweep_t sweep_cur, sweep_nxt;
	logic [7:0]       duty_bits;
	logic [3:0]       sample_d;

	assign cfg_ready = 1'b1;
	assign move      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_channel_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			second_channel_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			command_s1      <= command;
			reg_index_s1    <= reg_index;
			reg_value_s1    <= reg_value;
			enable_value_s1 <= enable_value;
		end
	end

	pwsc_sweep u_sweep_cur (
		.period         (period_q),
		.settings       (sweep_set_q),
		.second_channel (second_channel_q),
		.sweep          (sweep_cur)
	);

	always_comb begin
		duty_select_d  = duty_select_q;
		loop_halt_d    = loop_halt_q;
		const_vol_d    = const_vol_q;
		volume_d       = volume_q;
		sweep_set_d    = sweep_set_q;
		sweep_reload_d = sweep_reload_q;
		sweep_div_d    = sweep_div_q;
		period_d       = period_q;
		timer_d        = timer_q;
		step_d         = step_q;
		phase_d        = phase_q;
		length_d       = length_q;
		enabled_d      = enabled_q;
		env_start_d    = env_start_q;
		env_div_d      = env_div_q;
		decay_d        = decay_q;

		case (command_s1)
			pwsc_pkg::CMD_WRITE: begin
				case (reg_index_s1)
					pwsc_pkg::REG_CTRL: begin
						duty_select_d = reg_value_s1[7:6];
						loop_halt_d   = reg_value_s1[5];
						const_vol_d   = reg_value_s1[4];
						volume_d      = reg_value_s1[3:0];
					end
					pwsc_pkg::REG_SWEEP: begin
						sweep_set_d    = reg_value_s1;
						sweep_reload_d = 1'b1;
					end
					pwsc_pkg::REG_PER_LO: begin
						period_d = {period_q[PW-1:8], reg_value_s1};
					end
					default: begin
						period_d    = {reg_value_s1[2:0], period_q[7:0]};
						timer_d     = {reg_value_s1[2:0], period_q[7:0]};
						step_d      = 3'd0;
						env_start_d = 1'b1;
						if (enabled_q) begin
							length_d = pwsc_pkg::length_load(reg_value_s1[7:3]);
						end
					end
				endcase
			end
			pwsc_pkg::CMD_TICK: begin
				phase_d = ~phase_q;
				// clock the timer on every second tick
				if (!phase_q) begin
					if (timer_q == '0) begin
						timer_d = period_q;
						step_d  = step_q + 3'd1;
					end else begin
						timer_d = timer_q - {{(PW-1){1'b0}}, 1'b1};
					end
				end
			end
			pwsc_pkg::CMD_QUARTER: begin
				if (env_start_q) begin
					env_start_d = 1'b0;
					decay_d     = pwsc_pkg::DECAY_MAX;
					env_div_d   = volume_q;
				end else if (env_div_q == 4'd0) begin
					env_div_d = volume_q;
					if (decay_q != 4'd0) begin
						decay_d = decay_q - 4'd1;
					end else if (loop_halt_q) begin
						decay_d = pwsc_pkg::DECAY_MAX;
					end
				end else begin
					env_div_d = env_div_q - 4'd1;
				end
			end
			pwsc_pkg::CMD_HALF: begin
				if (length_q != 8'd0 && !loop_halt_q) begin
					length_d = length_q - 8'd1;
				end
				if (sweep_div_q == 3'd0 && sweep_set_q[pwsc_pkg::SWP_ENABLE_BIT]
						&& sweep_set_q[2:0] != 3'd0 && !sweep_cur.muted) begin
					period_d = sweep_cur.target;
				end
				if (sweep_div_q == 3'd0 || sweep_reload_q) begin
					sweep_div_d    = sweep_set_q[6:4];
					sweep_reload_d = 1'b0;
				end else begin
					sweep_div_d = sweep_div_q - 3'd1;
				end
			end
			pwsc_pkg::CMD_ENABLE: begin
				enabled_d = enable_value_s1;
				if (!enable_value_s1) begin
					length_d = 8'd0;
				end
			end
			default: begin
			end
		endcase
	end

	pwsc_sweep u_sweep_nxt (
		.period         (period_d),
		.settings       (sweep_set_d),
		.second_channel (second_channel_q),
		.sweep          (sweep_nxt)
	);

	always_comb begin
		duty_bits = pwsc_pkg::duty_pattern(duty_select_d);
		sample_d  = 4'd0;
		if (!sweep_nxt.muted && duty_bits[step_d] && length_d != 8'd0) begin
			sample_d = const_vol_d ? volume_d : decay_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_select_q  <= '0;
			loop_halt_q    <= 1'b0;
			const_vol_q    <= 1'b0;
			volume_q       <= '0;
			sweep_set_q    <= '0;
			sweep_reload_q <= 1'b0;
			sweep_div_q    <= '0;
			period_q       <= '0;
			timer_q        <= '0;
			step_q         <= '0;
			phase_q        <= 1'b0;
			length_q       <= '0;
			enabled_q      <= 1'b0;
			env_start_q    <= 1'b0;
			env_div_q      <= '0;
			decay_q        <= '0;
		end else if (move) begin
			duty_select_q  <= duty_select_d;
			loop_halt_q    <= loop_halt_d;
			const_vol_q    <= const_vol_d;
			volume_q       <= volume_d;
			sweep_set_q    <= sweep_set_d;
			sweep_reload_q <= sweep_reload_d;
			sweep_div_q    <= sweep_div_d;
			period_q       <= period_d;
			timer_q        <= timer_d;
			step_q         <= step_d;
			phase_q        <= phase_d;
			length_q       <= length_d;
			enabled_q      <= enabled_d;
			env_start_q    <= env_start_d;
			env_div_q      <= env_div_d;
			decay_q        <= decay_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			sample_q        <= sample_d;
			length_active_q <= (length_d != 8'd0);
		end
	end

	assign out_valid     = out_valid_q;
	assign sample        = sample_q;
	assign length_active = length_active_q;

`ifndef SYNTHESIS
	a_stall_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input stage");

	a_move_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid_q)
		else $error("applied request produced no result");

	a_silent_without_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !length_active_q) |-> (sample_q == 4'd0))
		else $error("nonzero sample with length counter at zero");

	a_disabled_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		!enabled_q |-> (length_q == 8'd0))
		else $error("length counter loaded while channel disabled");
`endif

endmodule

[sim/pulse_wave_sound_channel_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_wave_sound_channel_tb - self-checking bench for the pulse channel
// Drives register writes, ticks, frame clocks and enable writes, with random
// gaps and output stalls, and checks each sample against a channel model
// kept in the bench or a pinned value, over both sweep negate settings.
// ----------------------------------------------------------------------------
module pulse_wave_sound_channel_tb;

	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int N_ROWS = 24;

	// length load values, entry 31 first
	localparam logic [255:0] LEN_LOADS = {
		8'd30, 8'd32, 8'd28, 8'd16, 8'd26, 8'd72, 8'd24, 8'd192,
		8'd22, 8'd96, 8'd20, 8'd48, 8'd18, 8'd24, 8'd16, 8'd12,
		8'd14, 8'd26, 8'd12, 8'd14, 8'd10, 8'd60, 8'd8, 8'd160,
		8'd6, 8'd80, 8'd4, 8'd40, 8'd2, 8'd20, 8'd254, 8'd10
	};
	// duty waveforms, pattern 3 first; bit k is step k
	localparam logic [31:0] DUTY_WAVES = {8'hF9, 8'h1E, 8'h06, 8'h02};

	typedef struct packed {
		logic [3:0] level;
		logic       len_on;
	} sample_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [1:0] idx;
		logic [7:0] val;
		logic       en;
		logic       pin;
		logic [3:0] level;
		logic       len_on;
	} row_t;

	localparam row_t DIRECTED [N_ROWS] = '{
		'{pwsc_pkg::CMD_TICK,    pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b1, 4'd0, 1'b0},
		'{CMD_UNUSED_HI,         pwsc_pkg::REG_PER_HI, 8'hFF, 1'b1, 1'b1, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_PER_HI, 8'hFF, 1'b0, 1'b1, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_ENABLE,  pwsc_pkg::REG_CTRL,   8'h00, 1'b1, 1'b1, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_CTRL,   8'hBF, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_SWEEP,  8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_PER_LO, 8'h10, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_PER_HI, 8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_TICK,    pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_QUARTER, pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_HALF,    pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_SWEEP,  8'hFF, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_HALF,    pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_SWEEP,  8'h89, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_HALF,    pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_CTRL,   8'h40, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_PER_LO, 8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_PER_HI, 8'h0F, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_QUARTER, pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_TICK,    pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_ENABLE,  pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b1, 4'd0, 1'b0},
		'{CMD_UNUSED_LO,         pwsc_pkg::REG_CTRL,   8'h00, 1'b0, 1'b1, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_WRITE,   pwsc_pkg::REG_PER_HI, 8'hF8, 1'b0, 1'b1, 4'd0, 1'b0},
		'{pwsc_pkg::CMD_ENABLE,  pwsc_pkg::REG_CTRL,   8'h00, 1'b1, 1'b0, 4'd0, 1'b0}
	};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] command = pwsc_pkg::CMD_TICK;
	logic [1:0] reg_index = pwsc_pkg::REG_CTRL;
	logic [7:0] reg_value = 8'h00;
	logic       enable_value = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [3:0] sample;
	logic       length_active;

	// pinned expectation travels with the request
	logic       pin_on = 1'b0;
	sample_t    pin_val = '0;

	logic       idle_on = 1'b0;
	logic       hold_off_req = 1'b0;
	int         quiet_cycles = 0;
	int         mismatches = 0;
	int         result_no = 0;
	sample_t    pending_samples[$];

	// channel model state
	logic        m_negate2;
	logic [1:0]  m_duty;
	logic        m_loop;
	logic        m_const;
	logic [3:0]  m_vol;
	logic [7:0]  m_sweep;
	logic        m_sweep_reload;
	logic [2:0]  m_sweep_div;
	logic [10:0] m_period;
	logic [10:0] m_timer;
	logic [2:0]  m_step;
	logic        m_phase;
	logic [7:0]  m_len;
	logic        m_enabled;
	logic        m_env_start;
	logic [3:0]  m_env_div;
	logic [3:0]  m_decay;

	pulse_wave_sound_channel dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.reg_index     (reg_index),
		.reg_value     (reg_value),
		.enable_value  (enable_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample        (sample),
		.length_active (length_active)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int sweep_goal();
		int p;
		int delta;
		p = int'(m_period);
		delta = int'(m_period >> m_sweep[2:0]);
		if (m_sweep[pwsc_pkg::SWP_NEGATE_BIT])
			return m_negate2 ? p - delta : p - delta - 1;
		return p + delta;
	endfunction

	// signed compare: a negative target never mutes
	function automatic logic period_silent();
		return m_period < pwsc_pkg::PERIOD_MIN || sweep_goal() > int'(11'h7FF);
	endfunction

	function automatic sample_t channel_step(input logic [2:0] cmd, input logic [1:0] idx,
			input logic [7:0] val, input logic en);
		sample_t r;
		int goal;
		case (cmd)
			pwsc_pkg::CMD_WRITE: begin
				case (idx)
					pwsc_pkg::REG_CTRL: begin
						m_duty = val[7:6];
						m_loop = val[5];
						m_const = val[4];
						m_vol = val[3:0];
					end
					pwsc_pkg::REG_SWEEP: begin
						m_sweep = val;
						m_sweep_reload = 1'b1;
					end
					pwsc_pkg::REG_PER_LO: m_period[7:0] = val;
					default: begin
						m_period[10:8] = val[2:0];
						m_step = '0;
						m_timer = m_period;
						m_env_start = 1'b1;
						if (m_enabled)
							m_len = LEN_LOADS[val[7:3]*8 +: 8];
					end
				endcase
			end
			pwsc_pkg::CMD_TICK: begin
				m_phase = ~m_phase;
				if (m_phase) begin
					if (m_timer == 0) begin
						m_timer = m_period;
						m_step = m_step + 3'd1;
					end else begin
						m_timer = m_timer - 11'd1;
					end
				end
			end
			pwsc_pkg::CMD_QUARTER: begin
				if (m_env_start) begin
					m_env_start = 1'b0;
					m_decay = pwsc_pkg::DECAY_MAX;
					m_env_div = m_vol;
				end else if (m_env_div == 0) begin
					m_env_div = m_vol;
					if (m_decay != 0)
						m_decay = m_decay - 4'd1;
					else if (m_loop)
						m_decay = pwsc_pkg::DECAY_MAX;
				end else begin
					m_env_div = m_env_div - 4'd1;
				end
			end
			pwsc_pkg::CMD_HALF: begin
				if (m_len != 0 && !m_loop)
					m_len = m_len - 8'd1;
				if (m_sweep_div == 0 && m_sweep[pwsc_pkg::SWP_ENABLE_BIT] && m_sweep[2:0] != 0 &&
						!period_silent()) begin
					goal = sweep_goal();
					m_period = goal[10:0];
				end
				if (m_sweep_div == 0 || m_sweep_reload) begin
					m_sweep_div = m_sweep[6:4];
					m_sweep_reload = 1'b0;
				end else begin
					m_sweep_div = m_sweep_div - 3'd1;
				end
			end
			pwsc_pkg::CMD_ENABLE: begin
				m_enabled = en;
				if (!en)
					m_len = '0;
			end
			default: ;
		endcase
		r.level = '0;
		if (!period_silent() && DUTY_WAVES[m_duty*8 + m_step] && m_len != 0)
			r.level = m_const ? m_vol : m_decay;
		r.len_on = (m_len != 0);
		return r;
	endfunction

	// predict on every accepted request, check every accepted result
	always @(posedge clk) begin
		sample_t want;
		logic moved;
		moved = 1'b0;
		if (!arst_n) begin
			m_negate2 = 1'b0;
			{m_duty, m_loop, m_const, m_vol, m_sweep, m_sweep_reload, m_sweep_div} = '0;
			{m_period, m_timer, m_step, m_phase, m_len, m_enabled} = '0;
			{m_env_start, m_env_div, m_decay} = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				m_negate2 = cfg_data;
				moved = 1'b1;
			end
			if (in_valid && !in_stall) begin
				want = channel_step(command, reg_index, reg_value, enable_value);
				pending_samples.push_back(pin_on ? pin_val : want);
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				result_no++;
				if (pending_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with no request pending: sample %0d len %0b",
							result_no, sample, length_active);
				end else begin
					want = pending_samples.pop_front();
					if (sample !== want.level || length_active !== want.len_on) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: sample exp %0d got %0d, length_active exp %0b got %0b",
								result_no, want.level, sample, want.len_on, length_active);
					end
				end
			end
		end
		quiet_cycles <= (moved || !arst_n) ? 0 : quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: random stall bursts, and one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				hold_off_req <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_req(input logic [2:0] cmd, input logic [1:0] idx, input logic [7:0] val,
			input logic en, input logic pin, input sample_t pinned);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		command <= cmd;
		reg_index <= idx;
		reg_value <= val;
		enable_value <= en;
		pin_on <= pin;
		pin_val <= pinned;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// hold the request side until every sample is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0) @(posedge clk);
	endtask

	task automatic write_negate_mode(input logic mode);
		cfg_data <= mode;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly ticks and frame clocks, with a full channel setup now and then
	task automatic random_run(input int count);
		logic [2:0] cmd;
		logic [1:0] idx;
		logic [7:0] val;
		logic en;
		int pick;
		for (int n = 0; n < count; n++) begin
			idx = 2'($urandom);
			val = 8'($urandom);
			en = 1'($urandom);
			if (n % 64 < 5) begin
				cmd = pwsc_pkg::CMD_WRITE;
				case (n % 64)
					0: begin
						cmd = pwsc_pkg::CMD_ENABLE;
						en = 1'b1;
					end
					1: idx = pwsc_pkg::REG_CTRL;
					2: idx = pwsc_pkg::REG_SWEEP;
					3: begin
						idx = pwsc_pkg::REG_PER_LO;
						if ($urandom_range(0, 1) == 0)
							val = 8'($urandom_range(0, 31));
					end
					default: begin
						idx = pwsc_pkg::REG_PER_HI;
						val[2:0] = '0;
					end
				endcase
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					cmd = pwsc_pkg::CMD_TICK;
				else if (pick < 58)
					cmd = pwsc_pkg::CMD_QUARTER;
				else if (pick < 68)
					cmd = pwsc_pkg::CMD_HALF;
				else if (pick < 90) begin
					cmd = pwsc_pkg::CMD_WRITE;
					if (idx == pwsc_pkg::REG_PER_LO && $urandom_range(0, 4) < 3)
						val = 8'($urandom_range(0, 31));
					if (idx == pwsc_pkg::REG_PER_HI && $urandom_range(0, 3) != 0)
						val[2:0] = '0;
				end else if (pick < 96) begin
					cmd = pwsc_pkg::CMD_ENABLE;
					en = ($urandom_range(0, 9) != 0);
				end else
					cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
			end
			send_req(cmd, idx, val, en, 1'b0, '0);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		foreach (DIRECTED[i])
			send_req(DIRECTED[i].cmd, DIRECTED[i].idx, DIRECTED[i].val, DIRECTED[i].en,
				DIRECTED[i].pin, {DIRECTED[i].level, DIRECTED[i].len_on});
		drain();

		write_negate_mode(1'b1);
		random_run(400);
		drain();

		// fill the pipe against a stalled output
		idle_on = 1'b0;
		hold_off_req <= 1'b1;
		random_run(40);
		drain();

		idle_on = 1'b1;
		write_negate_mode(1'b0);
		random_run(400);
		drain();

		write_negate_mode(1'b1);
		random_run(300);
		drain();

		idle_on = 1'b0;
		write_negate_mode(1'b0);
		random_run(360);
		drain();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
design/pwsc_pkg.sv
design/pwsc_sweep.sv
design/pulse_wave_sound_channel.sv
sim/pulse_wave_sound_channel_tb.sv
